// ----- sv/vmyp_pkg.sv -----
// ----------------------------------------------------------------------------
// vmyp_pkg
// Shared types and constants for the yaw/pitch look-at view matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vmyp_pkg;

	// Q2.14 axis entry
	typedef logic signed [15:0] q14_t;

	localparam logic signed [15:0] Q14_ONE = 16'sd16384;

	// binary angle to radians in Q30, applied as (r * SCALE + 2^15) >> 16
	localparam logic [32:0] ANGLE_SCALE = 33'd6746518852;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	// floor(v / d) = (v * ceil(2^37 / d)) >> 37, exact for v < 2^31, d <= 64
	localparam int unsigned RECIP_SHIFT = 37;
	localparam longint unsigned RECIP_42 = (64'd1 << 37) / 64'd42 + 64'd1;
	localparam longint unsigned RECIP_20 = ((64'd1 << 37) + 64'd19) / 64'd20;
	localparam longint unsigned RECIP_6  = ((64'd1 << 37) + 64'd5) / 64'd6;
	localparam longint unsigned RECIP_56 = ((64'd1 << 37) + 64'd55) / 64'd56;
	localparam longint unsigned RECIP_30 = ((64'd1 << 37) + 64'd29) / 64'd30;
	localparam longint unsigned RECIP_12 = ((64'd1 << 37) + 64'd11) / 64'd12;

endpackage

`default_nettype wire

// ----- sv/vmyp_sincos.sv -----
// ----------------------------------------------------------------------------
// vmyp_sincos
// Nine-stage pipelined sine and cosine of a 16-bit binary angle, Q2.14 out.
// ----------------------------------------------------------------------------
`default_nettype none

module vmyp_sincos (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [15:0]         angle,
	output vmyp_pkg::q14_t           sin_val,
	output vmyp_pkg::q14_t           cos_val
);

	localparam int LAST = 8;

	// octant fold
	logic [1:0]  quad_in;
	logic [13:0] frac_in;
	logic        swap_in;
	logic [14:0] r_in;

	assign quad_in = angle[15:14];
	assign frac_in = angle[13:0];
	assign swap_in = (frac_in > 14'd8192);
	assign r_in    = swap_in ? (15'd16384 - {1'b0, frac_in}) : {1'b0, frac_in};

	logic [1:0]  quad_s [1:LAST];
	logic        swap_s [1:LAST];

	logic [46:0] p1_s1;
	logic [29:0] x_s2, x_s3, x_s4, x_s5, x_s6, x_s7;
	logic [59:0] x2p_s2;
	logic [29:0] x2_s3, x2_s4, x2_s5, x2_s6, x2_s7;
	logic [65:0] ds_s3, dc_s3;
	logic [60:0] ps_s4, pc_s4, ps_s6, pc_s6, ps_s8, pc_s8;
	logic [66:0] ds_s5, dc_s5, ds_s7, dc_s7;

	// combinational pieces between stages
	logic [47:0] xr_sum;
	logic [29:0] x2_c3;
	logic [30:0] ts_c4, tc_c4, ts_c6, tc_c6, ts_c8, tc_c8;
	logic [30:0] vs_c5, vc_c5, vs_c7, vc_c7;
	logic [30:0] sin30, cos30;
	logic [31:0] sin_rnd, cos_rnd;
	vmyp_pkg::q14_t s_oct, c_oct, sq, cq;

	assign xr_sum = {1'b0, p1_s1} + 48'd32768;
	assign x2_c3  = x2p_s2[59:30];
	assign ts_c4  = vmyp_pkg::Q30_ONE - {2'b00, ds_s3[65:37]};
	assign tc_c4  = vmyp_pkg::Q30_ONE - {2'b00, dc_s3[65:37]};
	assign vs_c5  = ps_s4[60:30];
	assign vc_c5  = pc_s4[60:30];
	assign ts_c6  = vmyp_pkg::Q30_ONE - {1'b0, ds_s5[66:37]};
	assign tc_c6  = vmyp_pkg::Q30_ONE - {1'b0, dc_s5[66:37]};
	assign vs_c7  = ps_s6[60:30];
	assign vc_c7  = pc_s6[60:30];
	assign ts_c8  = vmyp_pkg::Q30_ONE - {1'b0, ds_s7[66:37]};
	assign tc_c8  = vmyp_pkg::Q30_ONE - {1'b0, dc_s7[66:37]};

	// tail of the cosine series and rounding to Q2.14
	assign sin30   = ps_s8[60:30];
	assign cos30   = vmyp_pkg::Q30_ONE - {1'b0, pc_s8[60:31]};
	assign sin_rnd = {1'b0, sin30} + 32'd32768;
	assign cos_rnd = {1'b0, cos30} + 32'd32768;
	assign s_oct   = vmyp_pkg::q14_t'(sin_rnd[31:16]);
	assign c_oct   = vmyp_pkg::q14_t'(cos_rnd[31:16]);
	assign sq      = swap_s[LAST] ? c_oct : s_oct;
	assign cq      = swap_s[LAST] ? s_oct : c_oct;

	// quadrant control travels with the data
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s[1] <= quad_in;
			swap_s[1] <= swap_in;
			for (int i = 2; i <= LAST; i++) begin
				quad_s[i] <= quad_s[i-1];
				swap_s[i] <= swap_s[i-1];
			end
		end
	end

	// series evaluation, one multiplier deep per stage
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1  <= 47'(r_in[13:0]) * 47'(vmyp_pkg::ANGLE_SCALE);
			x_s2   <= xr_sum[45:16];
			x2p_s2 <= 60'(xr_sum[45:16]) * 60'(xr_sum[45:16]);
			x_s3   <= x_s2;
			x2_s3  <= x2_c3;
			ds_s3  <= 66'(x2_c3) * 66'(vmyp_pkg::RECIP_42);
			dc_s3  <= 66'(x2_c3) * 66'(vmyp_pkg::RECIP_56);
			x_s4   <= x_s3;
			x2_s4  <= x2_s3;
			ps_s4  <= 61'(x2_s3) * 61'(ts_c4);
			pc_s4  <= 61'(x2_s3) * 61'(tc_c4);
			x_s5   <= x_s4;
			x2_s5  <= x2_s4;
			ds_s5  <= 67'(vs_c5) * 67'(vmyp_pkg::RECIP_20);
			dc_s5  <= 67'(vc_c5) * 67'(vmyp_pkg::RECIP_30);
			x_s6   <= x_s5;
			x2_s6  <= x2_s5;
			ps_s6  <= 61'(x2_s5) * 61'(ts_c6);
			pc_s6  <= 61'(x2_s5) * 61'(tc_c6);
			x_s7   <= x_s6;
			x2_s7  <= x2_s6;
			ds_s7  <= 67'(vs_c7) * 67'(vmyp_pkg::RECIP_6);
			dc_s7  <= 67'(vc_c7) * 67'(vmyp_pkg::RECIP_12);
			ps_s8  <= 61'(x_s7) * 61'(ts_c8);
			pc_s8  <= 61'(x2_s7) * 61'(tc_c8);
		end
	end

	// quadrant sign and swap
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_s[LAST])
				2'd0: begin
					sin_val <= sq;
					cos_val <= cq;
				end
				2'd1: begin
					sin_val <= cq;
					cos_val <= -sq;
				end
				2'd2: begin
					sin_val <= -sq;
					cos_val <= -cq;
				end
				default: begin
					sin_val <= -cq;
					cos_val <= sq;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/view_matrix_from_yaw_pitch_top.sv -----
// Pipeline: 14 stages.
// Throughput: one word per cycle; a stall at the output holds the whole pipeline.
// Rate is set by the 14-stage pipeline (sine/cosine series, axis
// products, translation dot products), each stage at most one multiplier deep.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// view_matrix_from_yaw_pitch_top
// Look-at view matrix (right, up, back axes and translation) from a camera
// position and yaw/pitch binary angles.
// ----------------------------------------------------------------------------
`default_nettype none

module view_matrix_from_yaw_pitch_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [31:0]  pos_x,
	input  wire logic signed [31:0]  pos_y,
	input  wire logic signed [31:0]  pos_z,
	input  wire logic [15:0]         yaw_angle,
	input  wire logic [15:0]         pitch_angle,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [15:0]       right_x,
	output logic signed [15:0]       right_z,
	output logic signed [15:0]       up_x,
	output logic signed [15:0]       up_y,
	output logic signed [15:0]       up_z,
	output logic signed [15:0]       back_x,
	output logic signed [15:0]       back_y,
	output logic signed [15:0]       back_z,
	output logic signed [31:0]       trans_x,
	output logic signed [31:0]       trans_y,
	output logic signed [31:0]       trans_z,
	output logic                     degenerate
);

	localparam int NSTG  = 14;
	localparam int POS_D = 11;

	logic en;
	logic vld_s [1:NSTG];

	assign en        = !vld_s[NSTG] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_s[NSTG];

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NSTG; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= NSTG; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// position rides along until the dot products
	logic signed [31:0] px_s [1:POS_D];
	logic signed [31:0] py_s [1:POS_D];
	logic signed [31:0] pz_s [1:POS_D];

	always_ff @(posedge clk) begin
		if (en) begin
			px_s[1] <= pos_x;
			py_s[1] <= pos_y;
			pz_s[1] <= pos_z;
			for (int i = 2; i <= POS_D; i++) begin
				px_s[i] <= px_s[i-1];
				py_s[i] <= py_s[i-1];
				pz_s[i] <= pz_s[i-1];
			end
		end
	end

	// stages 1..9: sine and cosine of both angles
	vmyp_pkg::q14_t sy_s9, cy_s9, sp_s9, cp_s9;

	vmyp_sincos u_yaw (
		.clk     (clk),
		.en      (en),
		.angle   (yaw_angle),
		.sin_val (sy_s9),
		.cos_val (cy_s9)
	);

	vmyp_sincos u_pitch (
		.clk     (clk),
		.en      (en),
		.angle   (pitch_angle),
		.sin_val (sp_s9),
		.cos_val (cp_s9)
	);

	// Q2.14 product rounding, half away from zero
	function automatic logic signed [15:0] rnd14(input logic signed [31:0] p);
		logic [31:0] m;
		logic [31:0] r;
		m = p[31] ? 32'(-p) : 32'(p);
		r = (m + 32'd8192) >> 14;
		return p[31] ? -16'(r) : 16'(r);
	endfunction

	// stage 10: trig cross products
	logic signed [31:0] cysp_s10, sysp_s10, cpcy_s10, cpsy_s10;
	vmyp_pkg::q14_t     sy_s10, cy_s10, sp_s10, cp_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			cysp_s10 <= 32'(cy_s9) * 32'(sp_s9);
			sysp_s10 <= 32'(sy_s9) * 32'(sp_s9);
			cpcy_s10 <= 32'(cp_s9) * 32'(cy_s9);
			cpsy_s10 <= 32'(cp_s9) * 32'(sy_s9);
			sy_s10   <= sy_s9;
			cy_s10   <= cy_s9;
			sp_s10   <= sp_s9;
			cp_s10   <= cp_s9;
		end
	end

	// stage 11: axes, with the vertical-view substitute
	vmyp_pkg::q14_t rx_s11, rz_s11, ux_s11, uy_s11, uz_s11, bx_s11, by_s11, bz_s11;
	logic           dg_s11;
	vmyp_pkg::q14_t cpcy_r, cpsy_r;
	logic           sneg, dg_c;

	assign cpcy_r = rnd14(cpcy_s10);
	assign cpsy_r = rnd14(cpsy_s10);
	assign sneg   = sp_s10[15];
	assign dg_c   = (sp_s10 == 16'sd0);

	always_ff @(posedge clk) begin
		if (en) begin
			bx_s11 <= rnd14(cysp_s10);
			by_s11 <= cp_s10;
			bz_s11 <= rnd14(sysp_s10);
			dg_s11 <= dg_c;
			if (dg_c) begin
				rx_s11 <= vmyp_pkg::Q14_ONE;
				rz_s11 <= '0;
				ux_s11 <= '0;
				uy_s11 <= '0;
				uz_s11 <= -cp_s10;
			end else begin
				rx_s11 <= sneg ? -sy_s10 : sy_s10;
				rz_s11 <= sneg ? cy_s10 : -cy_s10;
				ux_s11 <= sneg ? cpcy_r : -cpcy_r;
				uy_s11 <= sneg ? -sp_s10 : sp_s10;
				uz_s11 <= sneg ? cpsy_r : -cpsy_r;
			end
		end
	end

	// stage 12: position times axis entries
	logic signed [47:0] prx_s12, prz_s12;
	logic signed [47:0] pux_s12, puy_s12, puz_s12;
	logic signed [47:0] pbx_s12, pby_s12, pbz_s12;
	vmyp_pkg::q14_t     rx_s12, rz_s12, ux_s12, uy_s12, uz_s12, bx_s12, by_s12, bz_s12;
	logic               dg_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			prx_s12 <= 48'(px_s[POS_D]) * 48'(rx_s11);
			prz_s12 <= 48'(pz_s[POS_D]) * 48'(rz_s11);
			pux_s12 <= 48'(px_s[POS_D]) * 48'(ux_s11);
			puy_s12 <= 48'(py_s[POS_D]) * 48'(uy_s11);
			puz_s12 <= 48'(pz_s[POS_D]) * 48'(uz_s11);
			pbx_s12 <= 48'(px_s[POS_D]) * 48'(bx_s11);
			pby_s12 <= 48'(py_s[POS_D]) * 48'(by_s11);
			pbz_s12 <= 48'(pz_s[POS_D]) * 48'(bz_s11);
			rx_s12 <= rx_s11;
			rz_s12 <= rz_s11;
			ux_s12 <= ux_s11;
			uy_s12 <= uy_s11;
			uz_s12 <= uz_s11;
			bx_s12 <= bx_s11;
			by_s12 <= by_s11;
			bz_s12 <= bz_s11;
			dg_s12 <= dg_s11;
		end
	end

	// stage 13: negated dot products
	logic signed [50:0] nr_s13, nu_s13, nb_s13;
	vmyp_pkg::q14_t     rx_s13, rz_s13, ux_s13, uy_s13, uz_s13, bx_s13, by_s13, bz_s13;
	logic               dg_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			nr_s13 <= -(51'(prx_s12) + 51'(prz_s12));
			nu_s13 <= -(51'(pux_s12) + 51'(puy_s12) + 51'(puz_s12));
			nb_s13 <= -(51'(pbx_s12) + 51'(pby_s12) + 51'(pbz_s12));
			rx_s13 <= rx_s12;
			rz_s13 <= rz_s12;
			ux_s13 <= ux_s12;
			uy_s13 <= uy_s12;
			uz_s13 <= uz_s12;
			bx_s13 <= bx_s12;
			by_s13 <= by_s12;
			bz_s13 <= bz_s12;
			dg_s13 <= dg_s12;
		end
	end

	// Q16.16 rounding and saturation
	function automatic logic signed [31:0] sat_tr(input logic signed [50:0] n);
		logic [50:0] m;
		logic [50:0] r;
		m = n[50] ? 51'(-n) : 51'(n);
		r = (m + 51'd8192) >> 14;
		if (n[50]) begin
			if (r > 51'h8000_0000) return 32'sh8000_0000;
			return -32'(r);
		end
		if (r > 51'h7FFF_FFFF) return 32'sh7FFF_FFFF;
		return 32'(r);
	endfunction

	// stage 14: output word
	always_ff @(posedge clk) begin
		if (en) begin
			trans_x    <= sat_tr(nr_s13);
			trans_y    <= sat_tr(nu_s13);
			trans_z    <= sat_tr(nb_s13);
			right_x    <= rx_s13;
			right_z    <= rz_s13;
			up_x       <= ux_s13;
			up_y       <= uy_s13;
			up_z       <= uz_s13;
			back_x     <= bx_s13;
			back_y     <= by_s13;
			back_z     <= bz_s13;
			degenerate <= dg_s13;
		end
	end

	// substitute right axis on a vertical view
	a_degen_right: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> right_x == 16'sd16384 && right_z == 16'sd0)
		else $error("degenerate word without substituted right axis");

	// vertical view: up is the negated back y
	a_degen_up: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> up_x == 16'sd0 && up_y == 16'sd0 && up_z == -back_y)
		else $error("degenerate word with bad up axis");

	// normal view keeps a positive up y
	a_norm_up: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate |-> up_y > 16'sd0)
		else $error("non-degenerate word with up_y not positive");

endmodule

`default_nettype wire
